FILE: rtl/ortq_pkg.sv
// ----------------------------------------------------------------------------
// Order rate throttle queue package
// Shared types, command and status codes of the throttle.
// ----------------------------------------------------------------------------
package ortq_pkg;

  localparam int unsigned SEC_W = 17;
  localparam int unsigned MPS_W = 10;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned ST_W  = 4;
  localparam int unsigned ID_W  = 32;
  localparam int unsigned SYM_W = 16;
  localparam int unsigned PX_W  = 32;
  localparam int unsigned QTY_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEC_W-1:0] RST_WIN_START = 17'd0;
  localparam logic [SEC_W-1:0] RST_WIN_END   = 17'd86400;
  localparam logic [MPS_W-1:0] RST_MAX_PS    = 10'd100;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PS    = 2'd2;

  localparam logic [CMD_W-1:0] CMD_NEW    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DRAIN  = 3'd3;

  localparam logic [ST_W-1:0] ST_SENT        = 4'd0;
  localparam logic [ST_W-1:0] ST_QUEUED      = 4'd1;
  localparam logic [ST_W-1:0] ST_MODIFIED    = 4'd2;
  localparam logic [ST_W-1:0] ST_CANCELLED   = 4'd3;
  localparam logic [ST_W-1:0] ST_NOT_PENDING = 4'd4;
  localparam logic [ST_W-1:0] ST_OUTSIDE     = 4'd5;
  localparam logic [ST_W-1:0] ST_UNKNOWN     = 4'd6;
  localparam logic [ST_W-1:0] ST_FULL        = 4'd7;
  localparam logic [ST_W-1:0] ST_NONE        = 4'd8;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SYM_W-1:0] sym;
    logic [PX_W-1:0]  price;
    logic [QTY_W-1:0] qty;
    logic             side;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CHECK,
    OP_POP,
    OP_LOAD_KEY,
    OP_SET_NONE,
    OP_SCAN,
    OP_RELEASE,
    OP_ACT,
    OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    logic is_drain;
    logic early;
    logic drain_ok;
    logic scan_done;
    logic hit;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_DR_CHK,
    S_DR_WAIT,
    S_DR_SCAN,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

FILE: rtl/order_rate_throttle_queue_top.sv
// ----------------------------------------------------------------------------
// Order rate throttle queue
// Rate-limits new orders per second and parks the excess in a pending table.
//
//   channel | ports                           | direction
//   input   | in_valid / in_stall, in_*       | command word in
//   result  | out_valid / out_stall, out_*    | one result word per command
//   config  | cfg_we, cfg_index, cfg_wdata    | register write, no read-back
//
// A command the limiter settles at once passes accept, window check and the
// result stage; a search walks the table RAM one entry per cycle, and a drain
// rescans the table for every stale queued id it discards. Reset is
// synchronous and clears all control state and table valid bits. A new
// command is taken while the previous result word still waits on out_stall.
// ----------------------------------------------------------------------------
module order_rate_throttle_queue_top #(
  parameter int unsigned PENDING_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ortq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ortq_pkg::SEC_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ortq_pkg::CMD_W-1:0]      in_cmd,
  input  logic [ortq_pkg::SEC_W-1:0]      in_time_sec,
  input  logic [ortq_pkg::ID_W-1:0]       in_order_id,
  input  logic [ortq_pkg::SYM_W-1:0]      in_symbol_id,
  input  logic [ortq_pkg::PX_W-1:0]       in_price_ticks,
  input  logic [ortq_pkg::QTY_W-1:0]      in_quantity,
  input  logic                            in_side_sell,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ortq_pkg::ST_W-1:0]       out_status,
  output logic                            out_sent,
  output logic [ortq_pkg::ID_W-1:0]       out_out_order_id,
  output logic [ortq_pkg::SYM_W-1:0]      out_out_symbol_id,
  output logic [ortq_pkg::PX_W-1:0]       out_out_price_ticks,
  output logic [ortq_pkg::QTY_W-1:0]      out_out_quantity,
  output logic                            out_out_side_sell
);

  ortq_pkg::op_t      op;
  ortq_pkg::dp_stat_t stat;

  ortq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  ortq_dp #(.PENDING_DEPTH(PENDING_DEPTH)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_cmd              (in_cmd),
    .in_time_sec         (in_time_sec),
    .in_order_id         (in_order_id),
    .in_symbol_id        (in_symbol_id),
    .in_price_ticks      (in_price_ticks),
    .in_quantity         (in_quantity),
    .in_side_sell        (in_side_sell),
    .op                  (op),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_sent            (out_sent),
    .out_out_order_id    (out_out_order_id),
    .out_out_symbol_id   (out_out_symbol_id),
    .out_out_price_ticks (out_out_price_ticks),
    .out_out_quantity    (out_out_quantity),
    .out_out_side_sell   (out_out_side_sell)
  );

endmodule

FILE: rtl/ortq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ortq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/ortq_ctrl.sv
// ----------------------------------------------------------------------------
// Throttle controller
// Sequences accept, window check, table scan, drain and result hand-off.
// ----------------------------------------------------------------------------
module ortq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ortq_pkg::dp_stat_t stat,
  output ortq_pkg::op_t     op
);

  ortq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ortq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = ortq_pkg::OP_NOP;
    in_stall  = (state_r != ortq_pkg::S_IDLE);
    unique case (state_r)
      ortq_pkg::S_IDLE: begin
        if (in_valid) begin
          op        = ortq_pkg::OP_ACCEPT;
          state_nxt = ortq_pkg::S_CHK;
        end
      end
      ortq_pkg::S_CHK: begin
        if (stat.is_drain) begin
          state_nxt = ortq_pkg::S_DR_CHK;
        end else begin
          op        = ortq_pkg::OP_CHECK;
          state_nxt = stat.early ? ortq_pkg::S_RESP : ortq_pkg::S_SCAN;
        end
      end
      ortq_pkg::S_DR_CHK: begin
        if (stat.drain_ok) begin
          op        = ortq_pkg::OP_POP;
          state_nxt = ortq_pkg::S_DR_WAIT;
        end else begin
          op        = ortq_pkg::OP_SET_NONE;
          state_nxt = ortq_pkg::S_RESP;
        end
      end
      ortq_pkg::S_DR_WAIT: begin
        op        = ortq_pkg::OP_LOAD_KEY;
        state_nxt = ortq_pkg::S_DR_SCAN;
      end
      ortq_pkg::S_DR_SCAN: begin
        if (!stat.scan_done) begin
          op = ortq_pkg::OP_SCAN;
        end else if (stat.hit) begin
          op        = ortq_pkg::OP_RELEASE;
          state_nxt = ortq_pkg::S_RESP;
        end else begin
          state_nxt = ortq_pkg::S_DR_CHK;
        end
      end
      ortq_pkg::S_SCAN: begin
        if (!stat.scan_done) begin
          op = ortq_pkg::OP_SCAN;
        end else begin
          op        = ortq_pkg::OP_ACT;
          state_nxt = ortq_pkg::S_RESP;
        end
      end
      ortq_pkg::S_RESP: begin
        if (stat.out_free) begin
          op        = ortq_pkg::OP_LOAD_OUT;
          state_nxt = ortq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ortq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ortq_dp.sv
// ----------------------------------------------------------------------------
// Throttle datapath
// Config registers, rate counter, pending table scan, id FIFO and result word.
// ----------------------------------------------------------------------------
module ortq_dp #(
  parameter int unsigned PENDING_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ortq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ortq_pkg::SEC_W-1:0]          cfg_wdata,
  input  logic [ortq_pkg::CMD_W-1:0]          in_cmd,
  input  logic [ortq_pkg::SEC_W-1:0]          in_time_sec,
  input  logic [ortq_pkg::ID_W-1:0]           in_order_id,
  input  logic [ortq_pkg::SYM_W-1:0]          in_symbol_id,
  input  logic [ortq_pkg::PX_W-1:0]           in_price_ticks,
  input  logic [ortq_pkg::QTY_W-1:0]          in_quantity,
  input  logic                                in_side_sell,
  input  ortq_pkg::op_t                       op,
  output ortq_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ortq_pkg::ST_W-1:0]           out_status,
  output logic                                out_sent,
  output logic [ortq_pkg::ID_W-1:0]           out_out_order_id,
  output logic [ortq_pkg::SYM_W-1:0]          out_out_symbol_id,
  output logic [ortq_pkg::PX_W-1:0]           out_out_price_ticks,
  output logic [ortq_pkg::QTY_W-1:0]          out_out_quantity,
  output logic                                out_out_side_sell
);

  localparam int unsigned AW    = $clog2(PENDING_DEPTH);
  localparam int unsigned ENT_W = $bits(ortq_pkg::entry_t);
  localparam logic [AW-1:0] LAST = AW'(PENDING_DEPTH - 1);
  localparam logic [AW:0]   FULL = (AW+1)'(PENDING_DEPTH);

  logic [ortq_pkg::SEC_W-1:0] win_start_r, win_end_r, cur_sec_r;
  logic [ortq_pkg::MPS_W-1:0] max_ps_r, sent_cnt_r;

  logic [ortq_pkg::CMD_W-1:0] cmd_r;
  logic [ortq_pkg::SEC_W-1:0] t_r;
  ortq_pkg::entry_t           in_r;

  logic [PENDING_DEPTH-1:0] valid_r;
  logic [AW-1:0]            head_r, tail_r;
  logic [AW:0]              count_r;

  logic [ortq_pkg::ID_W-1:0] key_r;
  logic [AW:0]               scan_idx_r;
  logic                      p_vld_r;
  logic [AW-1:0]             p_idx_r;
  logic                      hit_r, end_r, free_found_r;
  logic [AW-1:0]             hit_idx_r, free_idx_r;
  ortq_pkg::entry_t          ent_r;

  logic [ortq_pkg::ST_W-1:0] res_status_r;
  logic                      res_sent_r;
  ortq_pkg::entry_t          res_ent_r;

  logic                      out_valid_r;
  logic [ortq_pkg::ST_W-1:0] out_status_r;
  logic                      out_sent_r;
  ortq_pkg::entry_t          out_ent_r;

  logic                      ent_we, fifo_we;
  logic [AW-1:0]             ent_waddr;
  ortq_pkg::entry_t          ent_wdata, ent_rd;
  logic [ENT_W-1:0]          ent_rd_raw;
  logic [ortq_pkg::ID_W-1:0] fifo_rd;

  logic outside, unknown, can_send, can_queue;
  logic [AW-1:0] k_idx;

  assign outside   = (t_r < win_start_r) || (t_r >= win_end_r);
  assign unknown   = !(cmd_r == ortq_pkg::CMD_NEW || cmd_r == ortq_pkg::CMD_MODIFY
                       || cmd_r == ortq_pkg::CMD_CANCEL);
  assign can_send  = sent_cnt_r < max_ps_r;
  assign k_idx     = hit_r ? hit_idx_r : free_idx_r;
  assign can_queue = (hit_r || free_found_r) && (count_r < FULL);
  assign ent_rd    = ortq_pkg::entry_t'(ent_rd_raw);

  assign stat.is_drain  = (cmd_r == ortq_pkg::CMD_DRAIN);
  assign stat.early     = outside || unknown || ((cmd_r == ortq_pkg::CMD_NEW) && can_send);
  assign stat.drain_ok  = (count_r != '0) && can_send;
  assign stat.scan_done = hit_r || end_r;
  assign stat.hit       = hit_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    ent_we    = 1'b0;
    fifo_we   = 1'b0;
    ent_waddr = k_idx;
    ent_wdata = in_r;
    if (op == ortq_pkg::OP_ACT) begin
      case (cmd_r)
        ortq_pkg::CMD_NEW: begin
          ent_we  = can_queue;
          fifo_we = can_queue;
        end
        ortq_pkg::CMD_MODIFY: begin
          ent_we    = hit_r;
          ent_waddr = hit_idx_r;
          ent_wdata = '{id: ent_r.id, sym: ent_r.sym, price: in_r.price,
                        qty: in_r.qty, side: ent_r.side};
        end
        default: begin
          ent_we = 1'b0;
        end
      endcase
    end
  end

  ortq_ram #(.WIDTH(ENT_W), .DEPTH(PENDING_DEPTH)) u_ent_ram (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ENT_W'(ent_wdata)),
    .rd_addr (scan_idx_r[AW-1:0]),
    .rd_data (ent_rd_raw)
  );

  ortq_ram #(.WIDTH(ortq_pkg::ID_W), .DEPTH(PENDING_DEPTH)) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (tail_r),
    .wr_data (in_r.id),
    .rd_addr (head_r),
    .rd_data (fifo_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= ortq_pkg::RST_WIN_START;
      win_end_r   <= ortq_pkg::RST_WIN_END;
      max_ps_r    <= ortq_pkg::RST_MAX_PS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ortq_pkg::REG_WIN_START: win_start_r <= cfg_wdata;
        ortq_pkg::REG_WIN_END:   win_end_r   <= cfg_wdata;
        ortq_pkg::REG_MAX_PS:    max_ps_r    <= cfg_wdata[ortq_pkg::MPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == ortq_pkg::OP_ACCEPT) begin
      cmd_r <= in_cmd;
      t_r   <= in_time_sec;
      in_r  <= '{id: in_order_id, sym: in_symbol_id, price: in_price_ticks,
                 qty: in_quantity, side: in_side_sell};
    end
    if (op == ortq_pkg::OP_CHECK) begin
      key_r <= in_r.id;
    end else if (op == ortq_pkg::OP_LOAD_KEY) begin
      key_r <= fifo_rd;
    end
    if (p_vld_r && !hit_r && valid_r[p_idx_r] && (ent_rd.id == key_r)) begin
      hit_idx_r <= p_idx_r;
      ent_r     <= ent_rd;
    end
    if (p_vld_r && !free_found_r && !valid_r[p_idx_r]) begin
      free_idx_r <= p_idx_r;
    end
    if (op == ortq_pkg::OP_SCAN) begin
      p_idx_r <= scan_idx_r[AW-1:0];
    end
    if (op == ortq_pkg::OP_ACCEPT) begin
      res_ent_r <= '0;
    end else if (op == ortq_pkg::OP_CHECK) begin
      if (!outside && (cmd_r == ortq_pkg::CMD_NEW) && can_send) begin
        res_ent_r <= in_r;
      end
    end else if (op == ortq_pkg::OP_RELEASE) begin
      res_ent_r <= ent_r;
    end
    if (op == ortq_pkg::OP_LOAD_OUT) begin
      out_status_r <= res_status_r;
      out_sent_r   <= res_sent_r;
      out_ent_r    <= res_ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_sec_r    <= '0;
      sent_cnt_r   <= '0;
      valid_r      <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      p_vld_r      <= 1'b0;
      hit_r        <= 1'b0;
      end_r        <= 1'b0;
      free_found_r <= 1'b0;
      res_status_r <= ortq_pkg::ST_NONE;
      res_sent_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      p_vld_r <= (op == ortq_pkg::OP_SCAN) && (scan_idx_r < FULL);
      if ((op == ortq_pkg::OP_CHECK) || (op == ortq_pkg::OP_LOAD_KEY)) begin
        hit_r        <= 1'b0;
        end_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else if (p_vld_r) begin
        if (!hit_r && valid_r[p_idx_r] && (ent_rd.id == key_r)) begin
          hit_r <= 1'b1;
        end
        if (!free_found_r && !valid_r[p_idx_r]) begin
          free_found_r <= 1'b1;
        end
        if (p_idx_r == LAST) begin
          end_r <= 1'b1;
        end
      end
      if (op == ortq_pkg::OP_LOAD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        ortq_pkg::OP_ACCEPT: begin
          if (in_time_sec != cur_sec_r) begin
            cur_sec_r  <= in_time_sec;
            sent_cnt_r <= '0;
          end
          res_status_r <= ortq_pkg::ST_NONE;
          res_sent_r   <= 1'b0;
        end
        ortq_pkg::OP_CHECK: begin
          scan_idx_r <= '0;
          if (outside) begin
            res_status_r <= ortq_pkg::ST_OUTSIDE;
          end else if (unknown) begin
            res_status_r <= ortq_pkg::ST_UNKNOWN;
          end else if ((cmd_r == ortq_pkg::CMD_NEW) && can_send) begin
            res_status_r <= ortq_pkg::ST_SENT;
            res_sent_r   <= 1'b1;
            sent_cnt_r   <= sent_cnt_r + 1'b1;
          end
        end
        ortq_pkg::OP_POP: begin
          head_r  <= (head_r == LAST) ? '0 : head_r + 1'b1;
          count_r <= count_r - 1'b1;
        end
        ortq_pkg::OP_LOAD_KEY: begin
          scan_idx_r <= '0;
        end
        ortq_pkg::OP_SET_NONE: begin
          res_status_r <= ortq_pkg::ST_NONE;
        end
        ortq_pkg::OP_SCAN: begin
          if (scan_idx_r < FULL) begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        ortq_pkg::OP_RELEASE: begin
          valid_r[hit_idx_r] <= 1'b0;
          sent_cnt_r         <= sent_cnt_r + 1'b1;
          res_status_r       <= ortq_pkg::ST_SENT;
          res_sent_r         <= 1'b1;
        end
        ortq_pkg::OP_ACT: begin
          case (cmd_r)
            ortq_pkg::CMD_NEW: begin
              if (can_queue) begin
                valid_r[k_idx] <= 1'b1;
                tail_r         <= (tail_r == LAST) ? '0 : tail_r + 1'b1;
                count_r        <= count_r + 1'b1;
                res_status_r   <= ortq_pkg::ST_QUEUED;
              end else begin
                res_status_r <= ortq_pkg::ST_FULL;
              end
            end
            ortq_pkg::CMD_MODIFY: begin
              res_status_r <= hit_r ? ortq_pkg::ST_MODIFIED : ortq_pkg::ST_NOT_PENDING;
            end
            default: begin
              if (hit_r) begin
                valid_r[hit_idx_r] <= 1'b0;
                res_status_r       <= ortq_pkg::ST_CANCELLED;
              end else begin
                res_status_r <= ortq_pkg::ST_NOT_PENDING;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_sent            = out_sent_r;
  assign out_out_order_id    = out_ent_r.id;
  assign out_out_symbol_id   = out_ent_r.sym;
  assign out_out_price_ticks = out_ent_r.price;
  assign out_out_quantity    = out_ent_r.qty;
  assign out_out_side_sell   = out_ent_r.side;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("pending count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == ortq_pkg::OP_POP) |-> (count_r != '0))
    else $error("pop from empty id queue");

  a_release_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (op == ortq_pkg::OP_RELEASE) |-> (hit_r && valid_r[hit_idx_r]))
    else $error("release without a live table entry");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == ortq_pkg::OP_LOAD_OUT) |-> (!out_valid_r || !out_stall))
    else $error("result word overwritten while stalled");

endmodule

FILE: test/tb_order_rate_throttle_queue_top.sv
// ----------------------------------------------------------------------------
// Order rate throttle queue testbench
// Drives command words with random gaps and result stalls, predicts every
// result word from a local copy of the limiter, pending table and id queue,
// and compares each result field by field. Covers directed corner cases,
// table overflow and randomised phases over several register settings.
// ----------------------------------------------------------------------------
module tb_order_rate_throttle_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct packed {
    logic [ortq_pkg::ST_W-1:0]  status;
    logic                       sent;
    logic [ortq_pkg::ID_W-1:0]  id;
    logic [ortq_pkg::SYM_W-1:0] sym;
    logic [ortq_pkg::PX_W-1:0]  price;
    logic [ortq_pkg::QTY_W-1:0] qty;
    logic                       side;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ortq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ortq_pkg::SEC_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ortq_pkg::CMD_W-1:0] in_cmd = '0;
  logic [ortq_pkg::SEC_W-1:0] in_time_sec = '0;
  logic [ortq_pkg::ID_W-1:0] in_order_id = '0;
  logic [ortq_pkg::SYM_W-1:0] in_symbol_id = '0;
  logic [ortq_pkg::PX_W-1:0] in_price_ticks = '0;
  logic [ortq_pkg::QTY_W-1:0] in_quantity = '0;
  logic in_side_sell = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ortq_pkg::ST_W-1:0] out_status;
  logic out_sent;
  logic [ortq_pkg::ID_W-1:0] out_out_order_id;
  logic [ortq_pkg::SYM_W-1:0] out_out_symbol_id;
  logic [ortq_pkg::PX_W-1:0] out_out_price_ticks;
  logic [ortq_pkg::QTY_W-1:0] out_out_quantity;
  logic out_out_side_sell;

  order_rate_throttle_queue_top dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // throttle state mirror
  logic [ortq_pkg::SEC_W-1:0] win_start, win_end;
  logic [ortq_pkg::MPS_W-1:0] max_ps;
  logic [ortq_pkg::SEC_W-1:0] cur_sec;
  logic [ortq_pkg::MPS_W-1:0] sent_cnt;
  logic                       pend_v [DEPTH];
  ortq_pkg::entry_t           pend [DEPTH];
  logic [ortq_pkg::ID_W-1:0]  id_ring [DEPTH];
  int                         ring_head, ring_tail, ring_count;

  result_t expected_words[$];
  int errors = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;
  logic [ortq_pkg::ID_W-1:0] id_pool [40];
  logic [ortq_pkg::SEC_W-1:0] now_sec;

  function automatic int find_pending(logic [ortq_pkg::ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++) if (pend_v[i] && pend[i].id == id) return i;
    return -1;
  endfunction

  function automatic result_t throttle_predict(logic [ortq_pkg::CMD_W-1:0] cmd,
      logic [ortq_pkg::SEC_W-1:0] t, ortq_pkg::entry_t w);
    result_t r;
    int e, k;
    logic [ortq_pkg::ID_W-1:0] qid;
    r = '0;
    r.status = ortq_pkg::ST_NONE;
    if (t != cur_sec) begin
      cur_sec = t;
      sent_cnt = '0;
    end
    if (cmd == ortq_pkg::CMD_DRAIN) begin
      while (ring_count > 0 && sent_cnt < max_ps) begin
        qid = id_ring[ring_head];
        ring_head = (ring_head + 1) % DEPTH;
        ring_count--;
        e = find_pending(qid);
        if (e >= 0) begin
          pend_v[e] = 1'b0;
          sent_cnt++;
          r = '{ortq_pkg::ST_SENT, 1'b1, pend[e].id, pend[e].sym, pend[e].price,
                pend[e].qty, pend[e].side};
          return r;
        end
      end
      return r;
    end
    if (t < win_start || t >= win_end) begin
      r.status = ortq_pkg::ST_OUTSIDE;
      return r;
    end
    case (cmd)
      ortq_pkg::CMD_NEW: begin
        if (sent_cnt < max_ps) begin
          sent_cnt++;
          r = '{ortq_pkg::ST_SENT, 1'b1, w.id, w.sym, w.price, w.qty, w.side};
        end else begin
          k = find_pending(w.id);
          if (k < 0) for (int i = DEPTH - 1; i >= 0; i--) if (!pend_v[i]) k = i;
          if (k < 0 || ring_count >= DEPTH) r.status = ortq_pkg::ST_FULL;
          else begin
            pend_v[k] = 1'b1;
            pend[k] = w;
            id_ring[ring_tail] = w.id;
            ring_tail = (ring_tail + 1) % DEPTH;
            ring_count++;
            r.status = ortq_pkg::ST_QUEUED;
          end
        end
      end
      ortq_pkg::CMD_MODIFY: begin
        e = find_pending(w.id);
        if (e < 0) r.status = ortq_pkg::ST_NOT_PENDING;
        else begin
          pend[e].price = w.price;
          pend[e].qty = w.qty;
          r.status = ortq_pkg::ST_MODIFIED;
        end
      end
      ortq_pkg::CMD_CANCEL: begin
        e = find_pending(w.id);
        if (e < 0) r.status = ortq_pkg::ST_NOT_PENDING;
        else begin
          pend_v[e] = 1'b0;
          r.status = ortq_pkg::ST_CANCELLED;
        end
      end
      default: r.status = ortq_pkg::ST_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 9);
  endfunction

  // result side: stall, check
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected, status %0d", out_status);
          errors++;
        end else begin
          result_t x;
          x = expected_words.pop_front();
          if (out_status !== x.status) begin
            $error("status exp %0d got %0d", x.status, out_status); errors++;
          end
          if (out_sent !== x.sent) begin
            $error("sent exp %0d got %0d", x.sent, out_sent); errors++;
          end
          if (out_out_order_id !== x.id) begin
            $error("out_order_id exp %h got %h", x.id, out_out_order_id); errors++;
          end
          if (out_out_symbol_id !== x.sym) begin
            $error("out_symbol_id exp %h got %h", x.sym, out_out_symbol_id); errors++;
          end
          if (out_out_price_ticks !== x.price) begin
            $error("out_price_ticks exp %h got %h", x.price, out_out_price_ticks); errors++;
          end
          if (out_out_quantity !== x.qty) begin
            $error("out_quantity exp %h got %h", x.qty, out_out_quantity); errors++;
          end
          if (out_out_side_sell !== x.side) begin
            $error("out_side_sell exp %0d got %0d", x.side, out_out_side_sell); errors++;
          end
        end
        stall_left = draw_wait();
      end else if (stall_left > 0) stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(logic [ortq_pkg::CMD_W-1:0] cmd, logic [ortq_pkg::SEC_W-1:0] t,
      logic [ortq_pkg::ID_W-1:0] id, logic [ortq_pkg::SYM_W-1:0] sym,
      logic [ortq_pkg::PX_W-1:0] px, logic [ortq_pkg::QTY_W-1:0] qty, logic side);
    int gap;
    ortq_pkg::entry_t w;
    result_t exp_w;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_time_sec <= t;
    in_order_id <= id;
    in_symbol_id <= sym;
    in_price_ticks <= px;
    in_quantity <= qty;
    in_side_sell <= side;
    do @(posedge clk); while (in_stall);
    w = '{id, sym, px, qty, side};
    exp_w = throttle_predict(cmd, t, w);
    expected_words = {expected_words, exp_w};
  endtask

  task automatic send_rand(logic [ortq_pkg::CMD_W-1:0] cmd, logic [ortq_pkg::SEC_W-1:0] t,
      logic [ortq_pkg::ID_W-1:0] id);
    send_word(cmd, t, id, ortq_pkg::SYM_W'($urandom), $urandom, $urandom,
              1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [ortq_pkg::CFG_IDX_W-1:0] idx,
      logic [ortq_pkg::SEC_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ortq_pkg::REG_WIN_START: win_start = val;
      ortq_pkg::REG_WIN_END: win_end = val;
      default: max_ps = val[ortq_pkg::MPS_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [ortq_pkg::SEC_W-1:0] ws, logic [ortq_pkg::SEC_W-1:0] we,
      logic [ortq_pkg::MPS_W-1:0] mps);
    settle();
    write_reg(ortq_pkg::REG_WIN_START, ws);
    write_reg(ortq_pkg::REG_WIN_END, we);
    write_reg(ortq_pkg::REG_MAX_PS, {{(ortq_pkg::SEC_W-ortq_pkg::MPS_W){1'b0}}, mps});
  endtask

  task automatic test_directed();
    send_word(ortq_pkg::CMD_NEW, 17'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b1);
    send_word(ortq_pkg::CMD_NEW, 17'd0, 32'h0, 16'h0, 32'h0, 32'h0, 1'b0);
    for (int c = 4; c < 8; c++) send_rand(ortq_pkg::CMD_CANCEL + 3'(c - 2), 17'd1, 32'd5);
    send_rand(ortq_pkg::CMD_MODIFY, 17'd1, 32'd5);
    send_rand(ortq_pkg::CMD_CANCEL, 17'd1, 32'd5);
    send_rand(ortq_pkg::CMD_DRAIN, 17'd1, 32'd5);
    set_regs(17'd100, 17'd86400, 10'd0);
    send_rand(ortq_pkg::CMD_NEW, 17'd99, 32'd7);
    send_rand(ortq_pkg::CMD_DRAIN, 17'd99, 32'd7);
    send_rand(ortq_pkg::CMD_NEW, 17'd100, 32'd7);
    send_rand(ortq_pkg::CMD_NEW, 17'd100, 32'd8);
    send_rand(ortq_pkg::CMD_NEW, 17'd100, 32'd7);
    send_rand(ortq_pkg::CMD_MODIFY, 17'd100, 32'd8);
    send_rand(ortq_pkg::CMD_CANCEL, 17'd100, 32'd8);
    send_rand(ortq_pkg::CMD_MODIFY, 17'd100, 32'd8);
    set_regs(17'd100, 17'd86400, 10'd1);
    send_rand(ortq_pkg::CMD_DRAIN, 17'd101, 32'd0);
    send_rand(ortq_pkg::CMD_DRAIN, 17'd101, 32'd0);
    send_rand(ortq_pkg::CMD_DRAIN, 17'd86399, 32'd0);
    send_rand(ortq_pkg::CMD_DRAIN, 17'd86399, 32'd0);
    send_rand(ortq_pkg::CMD_NEW, 17'd50, 32'd9);
  endtask

  task automatic test_table_full();
    set_regs(17'd0, 17'd86400, 10'd0);
    for (int i = 0; i < DEPTH + 4; i++) send_rand(ortq_pkg::CMD_NEW, 17'd200, 32'(1000 + i));
    for (int i = 0; i < 8; i++) send_rand(ortq_pkg::CMD_CANCEL, 17'd200, 32'(1000 + 3 * i));
    send_rand(ortq_pkg::CMD_NEW, 17'd200, 32'd5000);
    set_regs(17'd0, 17'd86400, 10'd1023);
    for (int i = 0; i < DEPTH + 2; i++) send_rand(ortq_pkg::CMD_DRAIN, 17'd201, 32'd0);
  endtask

  task automatic test_random(int n, logic [ortq_pkg::SEC_W-1:0] ws,
      logic [ortq_pkg::SEC_W-1:0] we, logic [ortq_pkg::MPS_W-1:0] mps,
      logic [ortq_pkg::SEC_W-1:0] t0);
    int sel;
    logic [ortq_pkg::CMD_W-1:0] cmd;
    logic [ortq_pkg::ID_W-1:0] id;
    set_regs(ws, we, mps);
    now_sec = t0;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 40) cmd = ortq_pkg::CMD_NEW;
      else if (sel < 55) cmd = ortq_pkg::CMD_MODIFY;
      else if (sel < 70) cmd = ortq_pkg::CMD_CANCEL;
      else if (sel < 95) cmd = ortq_pkg::CMD_DRAIN;
      else cmd = ortq_pkg::CMD_DRAIN + 3'($urandom_range(1, 4));
      id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 39)] : $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 2 && now_sec > 0) now_sec = now_sec - 17'd1;
      else if (sel < 10 && now_sec < 17'd86399) now_sec = now_sec + 17'd1;
      send_rand(cmd, now_sec, id);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    win_start = ortq_pkg::RST_WIN_START;
    win_end = ortq_pkg::RST_WIN_END;
    max_ps = ortq_pkg::RST_MAX_PS;
    cur_sec = '0;
    sent_cnt = '0;
    ring_head = 0;
    ring_tail = 0;
    ring_count = 0;
    for (int i = 0; i < DEPTH; i++) pend_v[i] = 1'b0;
    for (int i = 0; i < 40; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(260, 17'd0, 17'd86400, 10'd3, 17'd10);
    test_random(260, 17'd1000, 17'd1030, 10'd1, 17'd995);
    test_random(200, 17'd0, 17'd86400, 10'd0, 17'd500);
    test_random(200, 17'd0, 17'd86400, 10'd1023, 17'd86300);
    test_random(60, 17'd86400, 17'd0, 10'd2, 17'd70000);
    test_random(220, 17'd65536, 17'd86400, 10'd2, 17'd86370);
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: sim.f
rtl/ortq_pkg.sv
rtl/ortq_ram.sv
rtl/ortq_ctrl.sv
rtl/ortq_dp.sv
rtl/order_rate_throttle_queue_top.sv
test/tb_order_rate_throttle_queue_top.sv
